[sv/wgm_pkg.sv]
package wgm_pkg;

	// Request opcodes.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_LEN   = 2'd1,
		OP_SUBJ  = 2'd2,
		OP_EMPTY = 2'd3
	} wgm_op_t;

	// Wildcard characters in the pattern.
	localparam logic [7:0] GLOB_STAR = 8'h2A;
	localparam logic [7:0] GLOB_ANY  = 8'h3F;

	// One input request.
	typedef struct packed {
		wgm_op_t     opcode;
		logic [5:0]  position;
		logic [7:0]  char_value;
		logic [6:0]  pattern_length;
		logic        last_char;
	} wgm_req_t;

	// One result.
	typedef struct packed {
		logic matched;
	} wgm_rsp_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic       advance;
		logic       restart;
		logic [7:0] ch;
	} wgm_cell_ctl_t;

endpackage

[sv/wgm_if.sv]
// Input request channel.
interface wgm_req_if;
	logic              valid;
	logic              ready;
	wgm_pkg::wgm_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface wgm_rsp_if;
	logic              valid;
	logic              ready;
	wgm_pkg::wgm_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/wildcard_glob_matcher_unit.sv]
// Whole-string glob matcher with '*' and '?' wildcards.
// Requests arrive on req (valid/ready); a request is taken when both are high.
// Opcode load writes one pattern character at position, opcode length sets the
// pattern length (saturated to PATTERN_MAX), opcode subject streams one subject
// character, and opcode empty asks whether the empty string matches.
// Every request except a subject character without last_char restarts the
// subject. A subject character with last_char, and every empty query, give one
// result on rsp: matched is 1 when the whole subject matches the whole pattern.
// One request is taken per cycle while req.ready is high. A result passes through
// the internal stage and the output register onto rsp. Each pattern position is a
// cell holding its character and its active bit; activity moves one cell per
// character, and runs of stars are closed in one carry-chain add.
// When rsp is stalled, one further result can wait in the internal stage;
// after that req.ready drops until rsp.ready returns. No result is lost.
// Reset (arst_n low) clears the pattern length to zero, restarts the subject
// and empties the result path. Pattern characters are not cleared; a position
// below the length must be loaded before it is used.
module wildcard_glob_matcher_unit #(
	parameter int PATTERN_MAX = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	wgm_req_if.sink  req,
	wgm_rsp_if.source rsp
);
	import wgm_pkg::*;

	localparam int W     = PATTERN_MAX + 1;
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_d;
	logic             final_q;
	logic             acc;
	wgm_cell_ctl_t    ctl;
	logic [W-1:0]     act;
	logic [W-1:0]     prop;
	logic [W-1:0]     closed;
	logic [W-1:0]     raw;
	logic [W-1:0]     step;
	logic [W-1:0]     set_s1;
	logic             valid_s1;
	logic [W-1:0]     closed_s1;
	logic             out_valid_q;
	logic             matched_q;
	logic             out_free;
	logic             in_ready;
	logic             emit;

	// Handshake: the stage moves on when it is empty or the output register is free.
	assign out_free  = !out_valid_q || rsp.ready;
	assign in_ready  = !valid_s1 || out_free;
	assign req.ready = in_ready;
	assign acc       = req.valid && in_ready;

	// Broadcast control to the cells.
	always_comb begin
		ctl.ch      = req.data.char_value;
		ctl.advance = acc && (req.data.opcode == OP_SUBJ) && !req.data.last_char;
		ctl.restart = acc && !((req.data.opcode == OP_SUBJ) && !req.data.last_char);
	end

	// Decode of which requests produce a result.
	always_comb begin
		unique case (req.data.opcode)
			OP_LOAD:  emit = 1'b0;
			OP_LEN:   emit = 1'b0;
			OP_SUBJ:  emit = req.data.last_char;
			OP_EMPTY: emit = 1'b1;
			default:  emit = 1'b0;
		endcase
	end

	// Star closure of the current active set.
	wgm_closure #(.W(W)) u_close_cur (
		.gen    (act),
		.prop   (prop),
		.closed (closed)
	);

	// Row of pattern cells.
	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			logic wr_en;
			logic in_use;

			assign wr_en  = acc && (req.data.opcode == OP_LOAD) &&
				(int'(req.data.position) == gi);
			assign in_use = (len_q > LEN_W'(gi));

			wgm_cell #(.IS_HEAD(gi == 0)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.wr_en    (wr_en),
				.in_use   (in_use),
				.closed   (closed[gi]),
				.step_in  ((gi == 0) ? 1'b0 : step[(gi == 0) ? 0 : gi - 1]),
				.active   (act[gi]),
				.prop     (prop[gi]),
				.step_out (step[gi]),
				.raw_next (raw[gi])
			);
		end
	endgenerate

	// Position past the last pattern character: reached only by a step.
	assign act[PATTERN_MAX]  = final_q;
	assign prop[PATTERN_MAX] = 1'b0;
	assign step[PATTERN_MAX] = 1'b0;
	assign raw[PATTERN_MAX]  = step[PATTERN_MAX-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q <= 1'b0;
		end else if (ctl.restart) begin
			final_q <= 1'b0;
		end else if (ctl.advance) begin
			final_q <= raw[PATTERN_MAX];
		end
	end

	// Pattern length register.
	wgm_len_sat #(.PATTERN_MAX(PATTERN_MAX), .LEN_W(LEN_W)) u_len_sat (
		.pattern_length (req.data.pattern_length),
		.len            (len_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (acc && (req.data.opcode == OP_LEN)) begin
			len_q <= len_d;
		end
	end

	// Result stage: holds the active set whose closure gives the answer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			if (req.data.opcode == OP_EMPTY) begin
				set_s1 <= W'(1);
			end else begin
				set_s1 <= raw;
			end
		end
	end

	// Closure of the finished set; the answer is the bit at the pattern length.
	wgm_closure #(.W(W)) u_close_res (
		.gen    (set_s1),
		.prop   (prop),
		.closed (closed_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			matched_q <= closed_s1[len_q];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.data.matched = matched_q;

endmodule

[sv/wgm_cell.sv]
module wgm_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wgm_pkg::wgm_cell_ctl_t ctl,
	input  logic                   wr_en,
	input  logic                   in_use,
	input  logic                   closed,
	input  logic                   step_in,
	output logic                   active,
	output logic                   prop,
	output logic                   step_out,
	output logic                   raw_next
);
	import wgm_pkg::*;

	logic [7:0] char_q;
	logic       active_q;
	logic       is_star;
	logic       hit;

	// Pattern character held by this cell.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			char_q <= ctl.ch;
		end
	end

	// A star keeps its own position and passes activity on through the closure.
	// Any other character moves activity to the neighbor when it matches.
	always_comb begin
		is_star  = (char_q == GLOB_STAR);
		hit      = (char_q == GLOB_ANY) || (char_q == ctl.ch);
		prop     = in_use && is_star;
		step_out = closed && in_use && !is_star && hit;
		raw_next = (closed && prop) || step_in;
	end

	// Active bit of this position, before the star closure.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= IS_HEAD;
		end else if (ctl.restart) begin
			active_q <= IS_HEAD;
		end else if (ctl.advance) begin
			active_q <= raw_next;
		end
	end

	assign active = active_q;

endmodule

[sv/wgm_closure.sv]
module wgm_closure #(
	parameter int W = 65
) (
	input  logic [W-1:0] gen,
	input  logic [W-1:0] prop,
	output logic [W-1:0] closed
);

	logic [W-1:0] sum;

	// Activity runs up through each run of stars like a carry through an adder.
	// Every set bit that sits on a star starts a carry that stops at the first
	// position after the run, and the XOR marks every position it crossed.
	always_comb begin
		sum    = (gen & prop) + prop;
		closed = (sum ^ prop) | gen;
	end

endmodule

[sv/wgm_top_dummy_placeholder.sv]
module wgm_len_sat #(
	parameter int PATTERN_MAX = 64,
	parameter int LEN_W       = 7
) (
	input  logic [6:0]       pattern_length,
	output logic [LEN_W-1:0] len
);

	// Lengths above the pattern capacity saturate to the capacity.
	always_comb begin
		if (int'(pattern_length) > PATTERN_MAX) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = LEN_W'(pattern_length);
		end
	end

endmodule

[test/wildcard_glob_matcher_unit_tb.sv]
module wildcard_glob_matcher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wgm_pkg::*;

	localparam int PMAX        = 64;
	localparam int DIR_ROWS    = 25;
	localparam int RAND_ITEMS  = 425;
	localparam int STALL_LIMIT = 200;
	localparam int DRAIN_WAIT  = 10;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_Q = 8'h71;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [PMAX:0] LIVE_RESTART = {{PMAX{1'b0}}, 1'b1};

	typedef struct {
		wgm_req_t r;
		bit       chk;
		bit       val;
	} dir_row_t;

	logic clk;
	logic arst_n;

	wgm_req_if req ();
	wgm_rsp_if rsp ();

	wildcard_glob_matcher_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the matcher state.
	logic [7:0]    pat_mem [PMAX];
	int unsigned   pat_len = 0;
	logic [PMAX:0] live = LIVE_RESTART;
	bit [PMAX-1:0] loaded = '0;

	bit          match_expected [$];
	logic [7:0]  subj_buf [$];
	int unsigned fail_count = 0;
	int unsigned req_count = 0;
	int unsigned quiet_cycles = 0;
	bit          burst = 1'b0;
	dir_row_t    plan [DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A star can match an empty run, so it also enables the position after it.
	function automatic void close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live[i] && pat_mem[i] == GLOB_STAR)
				live[i+1] = 1'b1;
		end
	endfunction

	// Move every live position across one subject character.
	function automatic void shift_live(input logic [7:0] c);
		logic [PMAX:0] nxt;
		nxt = '0;
		close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_mem[i] == GLOB_STAR)
					nxt[i] = 1'b1;
				else if (pat_mem[i] == GLOB_ANY || pat_mem[i] == c)
					nxt[i+1] = 1'b1;
			end
		end
		live = nxt;
	endfunction

	// Apply one accepted request and tell whether it yields a match result.
	function automatic void predict_match(input wgm_req_t r, output bit gives, output bit m);
		gives = 1'b0;
		m = 1'b0;
		case (r.opcode)
			OP_LOAD: begin
				pat_mem[r.position] = r.char_value;
				loaded[r.position] = 1'b1;
				live = LIVE_RESTART;
			end
			OP_LEN: begin
				pat_len = (r.pattern_length > PMAX) ? PMAX : r.pattern_length;
				live = LIVE_RESTART;
			end
			OP_SUBJ: begin
				shift_live(r.char_value);
				if (r.last_char) begin
					close_stars();
					m = live[pat_len];
					gives = 1'b1;
					live = LIVE_RESTART;
				end
			end
			default: begin
				live = LIVE_RESTART;
				close_stars();
				m = live[pat_len];
				gives = 1'b1;
				live = LIVE_RESTART;
			end
		endcase
	endfunction

	// Number of pattern entries written without a hole, counted from zero.
	function automatic int unsigned written_prefix();
		int unsigned n;
		n = 0;
		while (n < PMAX && loaded[n])
			n++;
		return n;
	endfunction

	function automatic int unsigned draw_wait();
		return burst ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic dir_row_t row(input wgm_op_t op, input logic [5:0] pos,
			input logic [7:0] ch, input logic [6:0] len, input logic last,
			input bit chk, input bit val);
		dir_row_t d;
		d.r.opcode = op;
		d.r.position = pos;
		d.r.char_value = ch;
		d.r.pattern_length = len;
		d.r.last_char = last;
		d.chk = chk;
		d.val = val;
		return d;
	endfunction

	// Fields that the opcode does not use carry random values.
	function automatic wgm_req_t make_req(input wgm_op_t op);
		wgm_req_t r;
		r.opcode = op;
		r.position = 6'($urandom_range(0, 63));
		r.char_value = 8'($urandom_range(0, 255));
		r.pattern_length = 7'($urandom_range(0, 127));
		r.last_char = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic logic [7:0] pick_pat_char();
		case ($urandom_range(0, 7))
			0, 1: return GLOB_STAR;
			2: return GLOB_ANY;
			3: return CH_A;
			4: return CH_B;
			5: return 8'h00;
			6: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_subj_char();
		case ($urandom_range(0, 5))
			0: return CH_A;
			1: return CH_B;
			2: return 8'h00;
			3: return 8'hFF;
			4: return GLOB_STAR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Drive one request, wait for it to be taken, then record its outcome.
	task automatic send_req(input wgm_req_t r, input bit chk, input bit val);
		int unsigned gap;
		bit gives;
		bit m;
		gap = draw_wait();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (req.ready !== 1'b1);
		req_count++;
		predict_match(r, gives, m);
		if (gives)
			match_expected.push_back(chk ? val : m);
	endtask

	// Disturb the subject with a pattern write or a length change.
	task automatic send_noise();
		wgm_req_t r;
		int unsigned pre;
		if ($urandom_range(0, 1)) begin
			r = make_req(OP_LOAD);
		end else begin
			r = make_req(OP_LEN);
			pre = written_prefix();
			if (pre == PMAX && $urandom_range(0, 1))
				r.pattern_length = 7'($urandom_range(PMAX + 1, 127));
			else
				r.pattern_length = 7'($urandom_range(0, pre));
		end
		send_req(r, 1'b0, 1'b0);
	endtask

	// Stream the prepared subject; now and then it is cut off before its last mark.
	task automatic send_subject();
		wgm_req_t r;
		bit cut;
		cut = ($urandom_range(0, 14) == 0);
		if (subj_buf.size() == 0) begin
			send_req(make_req(OP_EMPTY), 1'b0, 1'b0);
			return;
		end
		foreach (subj_buf[i]) begin
			if ($urandom_range(0, 24) == 0)
				send_noise();
			r = make_req(OP_SUBJ);
			r.char_value = subj_buf[i];
			r.last_char = (i == subj_buf.size() - 1) && !cut;
			send_req(r, 1'b0, 1'b0);
		end
	endtask

	// Build a subject fitting the current pattern, a damaged, random or empty one.
	task automatic build_subject(input int unsigned kind);
		int unsigned n;
		subj_buf.delete();
		if (kind >= 1 && kind <= 8) begin
			for (int i = 0; i < pat_len; i++) begin
				if (pat_mem[i] == GLOB_STAR) begin
					n = $urandom_range(0, 3);
					repeat (n) subj_buf.push_back(pick_subj_char());
				end else if (pat_mem[i] == GLOB_ANY) begin
					subj_buf.push_back(8'($urandom_range(0, 255)));
				end else begin
					subj_buf.push_back(pat_mem[i]);
				end
			end
			if (kind >= 6) begin
				if (subj_buf.size() == 0)
					subj_buf.push_back(pick_subj_char());
				else
					subj_buf[$urandom_range(0, subj_buf.size() - 1)] = pick_subj_char();
			end
		end else if (kind == 9) begin
			n = $urandom_range(0, 6);
			repeat (n) subj_buf.push_back(pick_subj_char());
		end
	endtask

	// One pattern, its length, then a handful of subjects against it.
	task automatic run_episode();
		wgm_req_t r;
		int unsigned plen;
		int unsigned nsub;
		int unsigned sel;
		bit rev;
		burst = ($urandom_range(0, 3) == 0);
		sel = $urandom_range(0, 11);
		if (sel == 0)
			plen = PMAX;
		else if (sel == 1)
			plen = $urandom_range(9, 40);
		else
			plen = $urandom_range(0, 8);
		rev = 1'($urandom_range(0, 1));
		for (int j = 0; j < plen; j++) begin
			r = make_req(OP_LOAD);
			r.position = 6'(rev ? (plen - 1 - j) : j);
			r.char_value = pick_pat_char();
			send_req(r, 1'b0, 1'b0);
		end
		r = make_req(OP_LEN);
		if (plen == PMAX && $urandom_range(0, 1))
			r.pattern_length = 7'($urandom_range(PMAX + 1, 127));
		else
			r.pattern_length = 7'(plen);
		send_req(r, 1'b0, 1'b0);
		nsub = (plen > 8) ? $urandom_range(1, 3) : $urandom_range(2, 6);
		repeat (nsub) begin
			build_subject($urandom_range(0, 9));
			send_subject();
		end
	endtask

	// Stimulus: reset, directed table, random episodes, drain.
	initial begin : stimulus
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.data <= '0;
		plan = '{
			row(OP_EMPTY, 6'd0,  8'h00,     7'd0,   1'b0, 1'b1, 1'b1),
			row(OP_SUBJ,  6'd0,  CH_A,      7'd0,   1'b1, 1'b1, 1'b0),
			row(OP_LOAD,  6'd0,  GLOB_STAR, 7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_LEN,   6'd0,  8'h00,     7'd1,   1'b0, 1'b0, 1'b0),
			row(OP_EMPTY, 6'd0,  8'h00,     7'd0,   1'b0, 1'b1, 1'b1),
			row(OP_SUBJ,  6'd0,  8'h00,     7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  8'hFF,     7'd0,   1'b1, 1'b1, 1'b1),
			row(OP_LOAD,  6'd0,  GLOB_ANY,  7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_EMPTY, 6'd0,  8'h00,     7'd0,   1'b0, 1'b1, 1'b0),
			row(OP_SUBJ,  6'd0,  8'h00,     7'd0,   1'b1, 1'b0, 1'b0),
			row(OP_LOAD,  6'd1,  8'h00,     7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_LEN,   6'd0,  8'h00,     7'd2,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  CH_X,      7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  8'h00,     7'd0,   1'b1, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  CH_X,      7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  8'h01,     7'd0,   1'b1, 1'b0, 1'b0),
			row(OP_LOAD,  6'd63, 8'hFF,     7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_LEN,   6'd0,  8'h00,     7'd127, 1'b0, 1'b0, 1'b0),
			row(OP_LEN,   6'd0,  8'h00,     7'd2,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  CH_Q,      7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_LOAD,  6'd2,  GLOB_STAR, 7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_LEN,   6'd0,  8'h00,     7'd3,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  CH_A,      7'd0,   1'b0, 1'b0, 1'b0),
			row(OP_SUBJ,  6'd0,  8'h00,     7'd0,   1'b1, 1'b0, 1'b0),
			row(OP_EMPTY, 6'd0,  8'h00,     7'd0,   1'b0, 1'b0, 1'b0)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			send_req(plan[k].r, plan[k].chk, plan[k].val);

		while (req_count < DIR_ROWS + RAND_ITEMS)
			run_episode();
		req.valid <= 1'b0;

		while (match_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("wildcard_glob_matcher_unit regression: pass");
		else
			$display("wildcard_glob_matcher_unit regression: fail");
		$finish;
	end

	// Result side: random stalls, then compare against the oldest expectation.
	initial begin : result_check
		int unsigned stall;
		bit want;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
			if (match_expected.size() == 0) begin
				$error("unexpected result: matched %0b", rsp.data.matched);
				fail_count++;
			end else begin
				want = match_expected.pop_front();
				if (rsp.data.matched !== want) begin
					$error("matched: expected %0b, actual %0b", want, rsp.data.matched);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles where neither channel moves a request or a result.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("wildcard_glob_matcher_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

[sim.f]
sv/wgm_pkg.sv
sv/wgm_if.sv
sv/wgm_cell.sv
sv/wgm_closure.sv
sv/wgm_top_dummy_placeholder.sv
sv/wildcard_glob_matcher_unit.sv
test/wildcard_glob_matcher_unit_tb.sv
